// ===== src/sgcg_pkg.sv =====
// Shared types and constants of the scaled glyph column generator.
`timescale 1ns / 1ps

package sgcg_pkg;

	// Input transaction: a font load or a render request.
	typedef struct packed {
		logic        command;
		logic [10:0] font_address;
		logic [7:0]  font_data;
		logic [7:0]  char_code;
		logic [2:0]  band;
	} item_t;

	// Output transaction: one display column byte.
	typedef struct packed {
		logic [7:0] column_byte;
		logic       last;
	} result_t;

	// Command codes.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	// Configuration port geometry and register indexes.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] REG_SCALE_HEIGHT = 2'd0;
	localparam logic [1:0] REG_SCALE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_GAP_COLUMNS  = 2'd2;
	localparam logic [1:0] REG_MINI_FONTSET = 2'd3;

	// Code range of the mini font.
	localparam logic [7:0] MINI_FIRST = 8'h20;
	localparam logic [7:0] MINI_LAST  = 8'h60;

	// Largest scale and gap the block honors.
	localparam logic [3:0] SCALE_MAX = 4'd8;
	localparam logic [3:0] GAP_MAX   = 4'd8;

	// One row of the vertical stretch map: source bit is used when hit is set.
	typedef struct packed {
		logic       hit;
		logic [2:0] src_bit;
	} map_entry_t;

endpackage

// ===== src/scaled_glyph_column_generator.sv =====
// Character generator that emits scaled glyph column bytes for a paged display.
// A load transaction does not make the block busy. A render transaction keeps it busy
// through its divide, map, fetch, emit and gap phases, whose lengths follow the clamped
// scale_width and gap_columns. Throughput: one render transaction at a time;
// one column byte per cycle while emitting, unless the output stalls.
// Reset: arst_n clears the sequencer and output valid and loads the register defaults.
// The font store is not cleared; only entries that were written may be rendered.
`timescale 1ns / 1ps

module scaled_glyph_column_generator #(
	parameter int GLYPH_WIDTH = 5,
	parameter int GLYPH_COUNT = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input channel.
	input  logic                                item_valid,
	output logic                                item_stall,
	input  sgcg_pkg::item_t                     item,
	// Output channel.
	output logic                                res_valid,
	input  logic                                res_stall,
	output sgcg_pkg::result_t                   res,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sgcg_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [sgcg_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [sgcg_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import sgcg_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_WIDTH;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CW          = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MAP,
		ST_FETCH,
		ST_EMIT,
		ST_GAP
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers. Raw field values are kept so that a read returns
	// them exactly as written; clamping is applied where they are used.
	// ------------------------------------------------------------------
	logic [3:0] scale_height_q;
	logic [3:0] scale_width_q;
	logic [3:0] gap_columns_q;
	logic       mini_fontset_q;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_height_q <= 4'd1;
			scale_width_q  <= 4'd1;
			gap_columns_q  <= 4'd1;
			mini_fontset_q <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_SCALE_HEIGHT: scale_height_q <= pwdata[3:0];
				REG_SCALE_WIDTH:  scale_width_q  <= pwdata[3:0];
				REG_GAP_COLUMNS:  gap_columns_q  <= pwdata[3:0];
				REG_MINI_FONTSET: mini_fontset_q <= pwdata[0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SCALE_HEIGHT: prdata = {28'd0, scale_height_q};
			REG_SCALE_WIDTH:  prdata = {28'd0, scale_width_q};
			REG_GAP_COLUMNS:  prdata = {28'd0, gap_columns_q};
			REG_MINI_FONTSET: prdata = {31'd0, mini_fontset_q};
			default:          prdata = '0;
		endcase
	end

	// A zero scale behaves as one, and anything above eight as eight.
	function automatic logic [3:0] clamp_scale(input logic [3:0] v);
		logic [3:0] r;
		if (v == 4'd0) begin
			r = 4'd1;
		end else if (v > SCALE_MAX) begin
			r = SCALE_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [3:0] height_eff;
	logic [3:0] width_eff;
	logic [2:0] width_m1;
	logic [3:0] gap_eff;

	assign height_eff = clamp_scale(scale_height_q);
	assign width_eff  = clamp_scale(scale_width_q);
	assign width_m1   = 3'(width_eff - 4'd1);
	assign gap_eff    = (gap_columns_q > GAP_MAX) ? GAP_MAX : gap_columns_q;

	// ------------------------------------------------------------------
	// Sequencer state and working registers.
	// ------------------------------------------------------------------
	state_t         state_q;
	logic [2:0]     band_q;
	logic [3:0]     rem_q;
	logic [5:0]     quot_q;
	logic [2:0]     step_q;
	map_entry_t     map_q [8];
	logic [AW-1:0]  base_q;
	logic           blank_q;
	logic [CW-1:0]  col_q;
	logic [2:0]     rep_q;
	logic [3:0]     gap_left_q;
	logic           res_valid_q;
	result_t        res_q;

	logic           accept;
	logic           slot_free;
	logic           emit;
	logic [7:0]     glyph;
	logic           glyph_blank;
	logic [5:0]     dividend;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid & ~item_stall;
	assign slot_free  = ~res_valid_q | ~res_stall;
	assign emit       = slot_free && ((state_q == ST_EMIT) || (state_q == ST_GAP));
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// Glyph selection, including the optional mini font remap.
	always_comb begin
		if (mini_fontset_q) begin
			if ((item.char_code < MINI_FIRST) || (item.char_code > MINI_LAST)) begin
				glyph = 8'd0;
			end else begin
				glyph = item.char_code - MINI_FIRST;
			end
		end else begin
			glyph = item.char_code;
		end
	end

	assign glyph_blank = ({1'b0, glyph} >= 9'(GLYPH_COUNT));
	assign dividend    = {band_q, 3'b000};

	// ------------------------------------------------------------------
	// The shared compare and subtract unit. During the divide phase it runs
	// one restoring step of (8*band)/scale_height per cycle. During the map
	// phase it advances the remainder by one per output bit and wraps it at
	// scale_height, which steps the source bit exactly as the quotient
	// (8*band + i)/scale_height does.
	// ------------------------------------------------------------------
	logic [3:0] alu_a;
	logic [3:0] alu_diff;
	logic       alu_ge;
	logic [3:0] rem_next;

	always_comb begin
		if (state_q == ST_DIV) begin
			alu_a = {rem_q[2:0], dividend[step_q]};
		end else begin
			alu_a = rem_q + 4'd1;
		end
	end

	assign alu_ge   = (alu_a >= height_eff);
	assign alu_diff = alu_a - height_eff;
	assign rem_next = alu_ge ? alu_diff : alu_a;

	// ------------------------------------------------------------------
	// Font store: one write port for load transactions and one registered
	// read port addressed by the current glyph column.
	// ------------------------------------------------------------------
	logic [7:0]    font_mem [STORE_DEPTH];
	logic [7:0]    rd_q;
	logic [AW-1:0] rd_addr;
	logic          store_write;

	assign rd_addr     = base_q + AW'(col_q);
	assign store_write = accept && (item.command == CMD_LOAD)
		&& (int'(item.font_address) < STORE_DEPTH);

	always_ff @(posedge clk) begin
		if (store_write) begin
			font_mem[item.font_address[AW-1:0]] <= item.font_data;
		end
		rd_q <= font_mem[rd_addr];
	end

	// Vertical stretch of the fetched column through the map built above.
	logic [7:0] src_byte;
	logic [7:0] line;

	assign src_byte = blank_q ? 8'd0 : rd_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			line[i] = map_q[i].hit & src_byte[map_q[i].src_bit];
		end
	end

	logic col_last;
	logic rep_last;

	assign col_last = (col_q == CW'(GLYPH_WIDTH - 1));
	assign rep_last = (rep_q == width_m1);

	// ------------------------------------------------------------------
	// Sequencer. A render transaction runs six divide steps, eight map
	// steps, then for each glyph column one fetch step followed by
	// scale_width emitted bytes, and finally the gap bytes. The output
	// register is reloaded in the emit and gap phases whenever it is empty or being taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			step_q      <= '0;
			col_q       <= '0;
			rep_q       <= '0;
			gap_left_q  <= '0;
			band_q      <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			base_q      <= '0;
			blank_q     <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				map_q[i] <= '0;
			end
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.command == CMD_RENDER)) begin
						band_q  <= item.band;
						blank_q <= glyph_blank;
						base_q  <= AW'(int'(glyph) * GLYPH_WIDTH);
						rem_q   <= '0;
						quot_q  <= '0;
						step_q  <= 3'd5;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					quot_q <= {quot_q[4:0], alu_ge};
					if (step_q == 3'd0) begin
						state_q <= ST_MAP;
					end else begin
						step_q <= step_q - 3'd1;
					end
				end
				ST_MAP: begin
					map_q[step_q].hit     <= (quot_q < 6'd8);
					map_q[step_q].src_bit <= quot_q[2:0];
					rem_q                 <= rem_next;
					quot_q                <= quot_q + 6'(alu_ge);
					if (step_q == 3'd7) begin
						col_q   <= '0;
						rep_q   <= '0;
						state_q <= ST_FETCH;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						res_q.column_byte <= line;
						res_q.last        <= rep_last && col_last && (gap_eff == 4'd0);
						if (rep_last) begin
							rep_q <= '0;
							if (!col_last) begin
								col_q   <= col_q + CW'(1);
								state_q <= ST_FETCH;
							end else if (gap_eff == 4'd0) begin
								state_q <= ST_IDLE;
							end else begin
								gap_left_q <= gap_eff;
								state_q    <= ST_GAP;
							end
						end else begin
							rep_q <= rep_q + 3'd1;
						end
					end
				end
				ST_GAP: begin
					if (slot_free) begin
						res_q.column_byte <= 8'd0;
						res_q.last        <= (gap_left_q == 4'd1);
						gap_left_q        <= gap_left_q - 4'd1;
						if (gap_left_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
